// ===== design/kss_pkg.sv =====
// Shared types, constants and helpers of the scheduling state tracker.
package kss_pkg;

	localparam int NUM_CPUS    = 8;
	localparam int NUM_THREADS = 4096;
	localparam int TIDX_W      = $clog2(NUM_THREADS);
	localparam int CPU_IDX_W   = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int TID_W       = 22;
	localparam int CPU_W       = 3;
	localparam int OP_W        = 4;
	localparam int ST_W        = 3;
	localparam int IN_W        = 64;
	localparam int OUT_W       = 32;

	localparam logic [OP_W-1:0] OP_SYS_ENTRY  = 4'd0;
	localparam logic [OP_W-1:0] OP_SYS_EXIT   = 4'd1;
	localparam logic [OP_W-1:0] OP_IRQ_ENTRY  = 4'd2;
	localparam logic [OP_W-1:0] OP_IRQ_EXIT   = 4'd3;
	localparam logic [OP_W-1:0] OP_SOFT_ENTRY = 4'd4;
	localparam logic [OP_W-1:0] OP_SOFT_EXIT  = 4'd5;
	localparam logic [OP_W-1:0] OP_SOFT_RAISE = 4'd6;
	localparam logic [OP_W-1:0] OP_SWITCH     = 4'd7;
	localparam logic [OP_W-1:0] OP_FORK       = 4'd8;
	localparam logic [OP_W-1:0] OP_FREE       = 4'd9;
	localparam logic [OP_W-1:0] OP_DUMP       = 4'd10;
	localparam logic [OP_W-1:0] OP_WAKEUP     = 4'd11;

	localparam logic [ST_W-1:0] ST_NONE        = 3'd0;
	localparam logic [ST_W-1:0] ST_USER        = 3'd1;
	localparam logic [ST_W-1:0] ST_SYSCALL     = 3'd2;
	localparam logic [ST_W-1:0] ST_IRQ         = 3'd3;
	localparam logic [ST_W-1:0] ST_INTERRUPTED = 3'd3;
	localparam logic [ST_W-1:0] ST_SOFTIRQ     = 3'd4;
	localparam logic [ST_W-1:0] ST_BLOCKED     = 3'd4;
	localparam logic [ST_W-1:0] ST_IDLE        = 3'd5;
	localparam logic [ST_W-1:0] ST_WAIT_CPU    = 3'd5;
	localparam logic [ST_W-1:0] ST_UNKNOWN     = 3'd6;

	localparam logic [2:0] DS_WAIT_CPU = 3'd2;
	localparam logic [2:0] DS_BLOCKED  = 3'd5;

	typedef struct packed {
		logic [TID_W-1:0] parent;
		logic             pvalid;
		logic             sc;
		logic [ST_W-1:0]  st;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [7:0]       line;
		logic [2:0]       ds;
		logic             run;
		logic [TID_W-1:0] oth;
		logic [TID_W-1:0] tid;
		logic [CPU_W-1:0] cpu;
		logic [OP_W-1:0]  op;
	} item_t;

	typedef struct packed {
		logic              load;
		logic              clear;
		logic              rd2;
		logic              exec;
		logic              fin;
		logic [TIDX_W-1:0] clr_addr;
	} cmd_t;

	typedef struct packed {
		logic is_switch;
		logic out_free;
	} stat_t;

	function automatic logic tid_ok(input logic [TID_W-1:0] t);
		return t < TID_W'(NUM_THREADS);
	endfunction

endpackage

// ===== design/kss_ram.sv =====
// Generic single-port RAM with registered read.
module kss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== design/kss_ctrl.sv =====
// Controller state machine: table clearing pass and per-request sequencing.
module kss_ctrl import kss_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  stat_t stat,
	output cmd_t  cmd
);
	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;
	localparam logic [1:0] S_RD2   = 2'd3;

	logic [1:0]        state_q;
	logic [TIDX_W-1:0] clr_q;
	logic              ph1_q;

	assign s_tready     = (state_q == S_IDLE) && stat.out_free;
	assign cmd.load     = s_tready && s_tvalid;
	assign cmd.clear    = (state_q == S_CLEAR);
	assign cmd.rd2      = (state_q == S_RD2);
	assign cmd.exec     = (state_q == S_EXEC);
	assign cmd.fin      = cmd.exec && !(stat.is_switch && !ph1_q);
	assign cmd.clr_addr = clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			ph1_q   <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == TIDX_W'(NUM_THREADS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_EXEC;
						ph1_q   <= 1'b0;
					end
				end
				S_EXEC: begin
					if (cmd.fin) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_RD2;
						ph1_q   <= 1'b1;
					end
				end
				S_RD2: begin
					state_q <= S_EXEC;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// ===== design/kss_dp.sv =====
// Datapath: CPU records, thread entry update logic and result register.
module kss_dp import kss_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output stat_t              stat,
	input  logic [IN_W-1:0]    s_tdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_W-1:0]   m_tdata,
	output logic               ram_we,
	output logic [TIDX_W-1:0]  ram_addr,
	output logic [ENTRY_W-1:0] ram_wdata,
	input  logic [ENTRY_W-1:0] ram_rdata
);
	logic [ST_W-1:0]  cpu_st_q  [NUM_CPUS];
	logic [TID_W-1:0] cpu_thr_q [NUM_CPUS];
	logic             cpu_val_q [NUM_CPUS];

	item_t             in_item, item_q;
	logic [TIDX_W-1:0] addr_q;
	logic              rng_q, ok_q, oor_q, ph1_q;
	logic              out_v_q;
	logic [OUT_W-1:0]  out_q;

	logic [CPU_IDX_W-1:0] in_ci, ci;
	logic [TID_W-1:0]     in_cur, in_addr, cur;
	logic                 in_has, in_uses_tid, in_rng, has, cpu_ok;

	entry_t           e, ne;
	logic             we_n, tgt_has, oor_n, cval_n;
	logic [ST_W-1:0]  cst_n, m;
	logic [TID_W-1:0] cthr_n;
	logic [ST_W-1:0]  o_tst;
	logic             o_sc, o_oor;

	assign in_item     = item_t'(s_tdata[$bits(item_t)-1:0]);
	assign in_ci       = CPU_IDX_W'(in_item.cpu);
	assign in_cur      = cpu_thr_q[in_ci];
	assign in_has      = cpu_val_q[in_ci];
	assign in_uses_tid = (in_item.op == OP_SWITCH) || (in_item.op == OP_FORK) ||
		(in_item.op == OP_FREE) || (in_item.op == OP_DUMP) || (in_item.op == OP_WAKEUP);
	assign in_addr     = in_uses_tid ? in_item.tid : in_cur;
	assign in_rng      = tid_ok(in_addr);

	assign ci     = CPU_IDX_W'(item_q.cpu);
	assign cur    = cpu_thr_q[ci];
	assign has    = cpu_val_q[ci];
	assign cpu_ok = 32'(item_q.cpu) < NUM_CPUS;
	assign e      = entry_t'(ram_rdata);
	assign m      = (ok_q && e.sc) ? ST_SYSCALL : ST_USER;

	always_comb begin
		ne      = e;
		we_n    = 1'b0;
		tgt_has = 1'b1;
		oor_n   = oor_q;
		cst_n   = cpu_st_q[ci];
		cthr_n  = cur;
		cval_n  = has;
		case (item_q.op)
			OP_SYS_ENTRY: begin
				ne.sc = 1'b1; ne.st = ST_SYSCALL; we_n = ok_q;
				cst_n = ST_SYSCALL; tgt_has = has;
			end
			OP_SYS_EXIT: begin
				ne.sc = 1'b0; ne.st = ST_USER; we_n = ok_q;
				cst_n = ST_USER; tgt_has = has;
			end
			OP_IRQ_ENTRY, OP_SOFT_ENTRY: begin
				ne.st = ST_INTERRUPTED; we_n = ok_q; tgt_has = has;
				cst_n = (item_q.op == OP_IRQ_ENTRY) ? ST_IRQ : ST_SOFTIRQ;
			end
			OP_IRQ_EXIT, OP_SOFT_EXIT: begin
				tgt_has = has;
				if (!has || cur == '0) begin
					cst_n = ST_IDLE;
				end else begin
					ne.st = m; we_n = ok_q; cst_n = m;
				end
			end
			OP_SWITCH: begin
				if (!ph1_q) begin
					ne.st = item_q.run ? ST_WAIT_CPU : ST_BLOCKED;
					we_n  = ok_q;
					oor_n = !rng_q;
				end else begin
					ne.st  = m; we_n = ok_q;
					cthr_n = item_q.oth; cval_n = 1'b1;
					cst_n  = (item_q.oth != '0) ? m : ST_IDLE;
				end
			end
			OP_FORK: begin
				ne.parent = item_q.oth; ne.pvalid = 1'b1;
				ne.st = ST_WAIT_CPU; ne.sc = 1'b1; we_n = ok_q;
			end
			OP_FREE: begin
				ne = '0; we_n = ok_q;
			end
			OP_DUMP: begin
				if (!e.pvalid) begin
					ne.parent = item_q.oth; ne.pvalid = 1'b1;
				end
				if (e.st == ST_NONE) begin
					if (item_q.ds == DS_WAIT_CPU) begin
						ne.st = ST_WAIT_CPU;
					end else if (item_q.ds == DS_BLOCKED) begin
						ne.st = ST_BLOCKED;
					end else begin
						ne.st = ST_UNKNOWN;
					end
				end
				we_n = ok_q;
			end
			OP_WAKEUP: begin
				if (e.st != ST_USER && e.st != ST_SYSCALL) begin
					ne.st = ST_WAIT_CPU;
				end
				we_n = ok_q;
			end
			default: begin
				tgt_has = has;
			end
		endcase
	end

	assign o_tst = (tgt_has && ok_q) ? ne.st : ST_NONE;
	assign o_sc  = tgt_has && ok_q && ne.sc;
	assign o_oor = oor_n || (tgt_has && !rng_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = ENTRY_W'(ne);
		ram_addr  = addr_q;
		if (cmd.clear) begin
			ram_we    = 1'b1;
			ram_addr  = cmd.clr_addr;
			ram_wdata = '0;
		end else if (cmd.load) begin
			ram_addr = TIDX_W'(in_addr);
		end else if (cmd.rd2) begin
			ram_addr = TIDX_W'(item_q.oth);
		end else if (cmd.exec) begin
			ram_we = we_n && cpu_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
			addr_q <= TIDX_W'(in_addr);
			rng_q  <= in_rng;
			ok_q   <= in_rng && (in_uses_tid || in_has);
		end else if (cmd.rd2) begin
			addr_q <= TIDX_W'(item_q.oth);
			rng_q  <= tid_ok(item_q.oth);
			ok_q   <= tid_ok(item_q.oth);
		end
		if (cmd.fin) begin
			if (cpu_ok) begin
				out_q <= OUT_W'({o_oor, o_sc, o_tst, cval_n, cthr_n, cst_n});
			end else begin
				out_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			oor_q   <= 1'b0;
			ph1_q   <= 1'b0;
			for (int i = 0; i < NUM_CPUS; i++) begin
				cpu_st_q[i]  <= ST_NONE;
				cpu_thr_q[i] <= '0;
				cpu_val_q[i] <= 1'b0;
			end
		end else begin
			if (cmd.load) begin
				oor_q <= 1'b0;
				ph1_q <= 1'b0;
			end else if (cmd.exec && !cmd.fin) begin
				oor_q <= oor_n;
				ph1_q <= 1'b1;
			end
			if (cmd.fin && cpu_ok) begin
				cpu_st_q[ci]  <= cst_n;
				cpu_thr_q[ci] <= cthr_n;
				cpu_val_q[ci] <= cval_n;
			end
			if (cmd.fin) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign stat.is_switch = (item_q.op == OP_SWITCH);
	assign stat.out_free  = !out_v_q || m_tready;
	assign m_tvalid       = out_v_q;
	assign m_tdata        = out_q;
endmodule

// ===== design/kernel_sched_state_tracker_top.sv =====
// Top level of the scheduling state tracker.
// Per request, the single thread table port does a read then a write per entry
// touched: idle reads it, execute writes it and registers the result; a switch
// adds a read state and a second execute for the other thread. One request is
// in flight at a time. Reset: asynchronous, active low; afterwards a clearing
// pass zeroes the thread table while no request is taken.
module kernel_sched_state_tracker_top import kss_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// op[3:0], cpu[6:4], tid[28:7], other_tid[50:29], prev_was_running[51],
	// dump_status[54:52], line_number[62:55], zero[63]
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// cpu_status[2:0], cpu_thread[24:3], cpu_thread_valid[25],
	// thread_status[28:26], thread_in_syscall[29], tid_out_of_range[30], zero[31]
	output logic [OUT_W-1:0] m_tdata
);
	cmd_t               cmd;
	stat_t              stat;
	logic               ram_we;
	logic [TIDX_W-1:0]  ram_addr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

	kss_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.stat(stat), .cmd(cmd)
	);

	kss_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.ram_we(ram_we), .ram_addr(ram_addr), .ram_wdata(ram_wdata),
		.ram_rdata(ram_rdata)
	);

	kss_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_THREADS)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while another is in flight");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.fin))
		else $error("result appeared without a finished request");

	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !s_tready)
		else $error("request taken during table clearing");

	a_fin_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> (cmd.exec && !cmd.load && !cmd.clear))
		else $error("finish outside execute");
endmodule
